FILE: design/blha_pkg.sv
// ----------------------------------------------------------------------------
// blha_pkg: shared types and codes for the block-list heap allocator
// Command and status codes, percentage width, divider result bundle.
// ----------------------------------------------------------------------------
package blha_pkg;

    localparam int CMD_W = 3;
    localparam int STATUS_W = 2;
    localparam int PCT_W = 7;
    localparam int PCT_CNT_W = $clog2(PCT_W);

    localparam logic [CMD_W-1:0] CMD_BUMP  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FIRST = 3'd1;
    localparam logic [CMD_W-1:0] CMD_BEST  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SPLIT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FREE  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_BLOCK = 2'd3;

    localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

    typedef struct packed {
        logic             done;
        logic [PCT_W-1:0] quotient;
    } div_res_t;

endpackage

FILE: design/block_list_heap_allocator_unit.sv
// ----------------------------------------------------------------------------
// block_list_heap_allocator_unit: block-table heap allocator
// Bump, first fit, best fit, split and coalescing free over a ring of cells.
// ----------------------------------------------------------------------------
// A command transaction is taken when start is high and busy is low; busy
// stays high until the result is out. The result is on the ports for exactly
// one cycle, marked by done, and must be captured then: there is no
// back-pressure. A command that fails its checks (unknown command, no space,
// zero size) answers from the check state. Others walk the block table, which
// lives in a ring of MAX_ENTRIES cells that rotates one entry per cycle past
// the controller while a pass runs: one pass to search, one pass to rewrite
// (longer when an entry is removed, so the ring realigns), one pass to gather
// statistics, then a percentage divide of PCT_W quotient bits. A bump skips
// the search pass, and the divide is skipped when no byte is free or the table
// is empty. A free that finds no block, or a command that finds the table
// full, answers after the decision, with no rewrite.
// ----------------------------------------------------------------------------
module block_list_heap_allocator_unit #(
    parameter int HEAP_BYTES  = 512,
    parameter int MAX_ENTRIES = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [blha_pkg::CMD_W-1:0]          command,
    input  logic [$clog2(HEAP_BYTES+1)-1:0]     request_size,
    input  logic [$clog2(HEAP_BYTES)-1:0]       block_address,
    output logic                                done,
    output logic [blha_pkg::STATUS_W-1:0]       status,
    output logic [$clog2(HEAP_BYTES)-1:0]       result_address,
    output logic [$clog2(HEAP_BYTES+1)-1:0]     result_size,
    output logic [$clog2(HEAP_BYTES+1)-1:0]     frontier,
    output logic [$clog2(MAX_ENTRIES+1)-1:0]    total_blocks,
    output logic [$clog2(MAX_ENTRIES+1)-1:0]    free_blocks,
    output logic [$clog2(HEAP_BYTES+1)-1:0]     allocated_bytes,
    output logic [blha_pkg::PCT_W-1:0]          fragmentation_pct
);

    localparam int AW = $clog2(HEAP_BYTES);
    localparam int SW = $clog2(HEAP_BYTES + 1);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CHECK  = 8'b0000_0010,
        S_SCAN   = 8'b0000_0100,
        S_DECIDE = 8'b0000_1000,
        S_UPDATE = 8'b0001_0000,
        S_STATS  = 8'b0010_0000,
        S_FINAL  = 8'b0100_0000,
        S_DIVIDE = 8'b1000_0000
    } state_t;

    // rewrite pass flavors
    typedef enum logic [1:0] {
        OP_REPLACE,
        OP_INSERT,
        OP_REMOVE
    } op_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] count_reg, count_next;
    logic [SW-1:0] frontier_reg, frontier_next;
    logic          done_reg, done_next;
    logic [CW-1:0] nfree_reg, nfree_next;
    logic [SW-1:0] alloc_reg, alloc_next;
    logic [blha_pkg::PCT_W-1:0] pct_reg, pct_next;
    logic          div_go_reg, div_go_next;

    logic [blha_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic [SW-1:0] req_reg, req_next;
    logic [AW-1:0] where_reg, where_next;

    // search results
    logic          found_reg, found_next;
    logic [CW-1:0] pick_idx_reg, pick_idx_next;
    logic [AW-1:0] pick_start_reg, pick_start_next;
    logic [SW-1:0] pick_size_reg, pick_size_next;
    logic          prev_used_reg, prev_used_next;
    logic [AW-1:0] prev_start_reg, prev_start_next;
    logic [SW-1:0] prev_size_reg, prev_size_next;
    logic          left_free_reg, left_free_next;
    logic [AW-1:0] left_start_reg, left_start_next;
    logic [SW-1:0] left_size_reg, left_size_next;
    logic          right_free_reg, right_free_next;
    logic [SW-1:0] right_size_reg, right_size_next;

    // rewrite pass
    logic [CW-1:0] upd_idx_reg, upd_idx_next;
    logic [AW-1:0] new_start_reg, new_start_next;
    logic [SW-1:0] new_size_reg, new_size_next;
    logic          new_used_reg, new_used_next;
    logic [AW-1:0] h_start_reg, h_start_next;
    logic [SW-1:0] h_size_reg, h_size_next;
    logic          h_used_reg, h_used_next;
    logic [CW-1:0] pend_count_reg, pend_count_next;
    logic [SW-1:0] pend_frontier_reg, pend_frontier_next;

    // result and statistics
    logic [blha_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [AW-1:0] res_addr_reg, res_addr_next;
    logic [SW-1:0] res_size_reg, res_size_next;
    logic [CW-1:0] acc_nfree_reg, acc_nfree_next;
    logic [SW-1:0] acc_alloc_reg, acc_alloc_next;
    logic [SW-1:0] acc_free_reg, acc_free_next;
    logic [SW-1:0] acc_big_reg, acc_big_next;
    logic [SW-1:0] f_reg, f_next;
    logic [SW-1:0] diff_reg, diff_next;

    // ring
    logic [AW-1:0] cs [MAX_ENTRIES];
    logic [SW-1:0] cz [MAX_ENTRIES];
    logic          cu [MAX_ENTRIES];
    logic [AW-1:0] e_start;
    logic [SW-1:0] e_size;
    logic          e_used;
    logic          ring_en;

    logic [AW-1:0] x_start;
    logic [SW-1:0] x_size;
    logic          x_used;
    logic          x_valid;
    logic          last_n;
    logic          fit;
    logic [SW:0]   bump_end;
    logic [SW-1:0] tail;
    logic [SW-1:0] f_sum;
    logic [SW-1:0] l_max;

    blha_pkg::div_res_t div_res;

    assign x_start = cs[0];
    assign x_size  = cz[0];
    assign x_used  = cu[0];
    assign x_valid = k_reg < count_reg;
    assign last_n  = k_reg == CW'(MAX_ENTRIES - 1);
    assign fit     = !x_used && (x_size >= req_reg);
    assign bump_end = {1'b0, frontier_reg} + {1'b0, req_reg};
    assign tail    = SW'(HEAP_BYTES) - frontier_reg;
    assign f_sum   = acc_free_reg + tail;
    assign l_max   = (acc_big_reg > tail) ? acc_big_reg : tail;
    assign ring_en = (state_reg == S_SCAN) || (state_reg == S_UPDATE)
                  || (state_reg == S_STATS);

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++)
        begin : g_cell
            if (gi == MAX_ENTRIES - 1)
            begin : g_tail
                blha_cell #(.AW(AW), .SW(SW)) u_cell (
                    .clk      (clk),
                    .en       (ring_en),
                    .start_in (e_start),
                    .size_in  (e_size),
                    .used_in  (e_used),
                    .start_out(cs[gi]),
                    .size_out (cz[gi]),
                    .used_out (cu[gi])
                );
            end
            else
            begin : g_body
                blha_cell #(.AW(AW), .SW(SW)) u_cell (
                    .clk      (clk),
                    .en       (ring_en),
                    .start_in (cs[gi+1]),
                    .size_in  (cz[gi+1]),
                    .used_in  (cu[gi+1]),
                    .start_out(cs[gi]),
                    .size_out (cz[gi]),
                    .used_out (cu[gi])
                );
            end
        end
    endgenerate

    blha_div #(.SW(SW)) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (div_go_reg),
        .diff (diff_reg),
        .den  (f_reg),
        .res  (div_res)
    );

    // Entry fed into the tail cell. Outside a rewrite the ring just rotates.
    // Insert: emit the used half, park the free rest, then run one behind.
    // Remove: run one behind, fold the dropped entry into its left partner,
    // then run direct; the pass runs to k == MAX_ENTRIES so the ring realigns.
    always_comb
    begin
        e_start     = x_start;
        e_size      = x_size;
        e_used      = x_used;
        h_start_next = h_start_reg;
        h_size_next  = h_size_reg;
        h_used_next  = h_used_reg;
        if (state_reg == S_UPDATE)
        begin
            case (op_reg)
                OP_REPLACE:
                begin
                    if (k_reg == upd_idx_reg)
                    begin
                        e_start = new_start_reg;
                        e_size  = new_size_reg;
                        e_used  = new_used_reg;
                    end
                end
                OP_INSERT:
                begin
                    if (k_reg == upd_idx_reg)
                    begin
                        e_start      = new_start_reg;
                        e_size       = new_size_reg;
                        e_used       = new_used_reg;
                        h_start_next = AW'(x_start + AW'(req_reg));
                        h_size_next  = x_size - req_reg;
                        h_used_next  = 1'b0;
                    end
                    else if (k_reg > upd_idx_reg)
                    begin
                        e_start      = h_start_reg;
                        e_size       = h_size_reg;
                        e_used       = h_used_reg;
                        h_start_next = x_start;
                        h_size_next  = x_size;
                        h_used_next  = x_used;
                    end
                end
                OP_REMOVE:
                begin
                    if (k_reg < upd_idx_reg)
                    begin
                        e_start      = h_start_reg;
                        e_size       = h_size_reg;
                        e_used       = h_used_reg;
                        h_start_next = x_start;
                        h_size_next  = x_size;
                        h_used_next  = x_used;
                    end
                    else if (k_reg == upd_idx_reg)
                    begin
                        e_start = h_start_reg;
                        e_size  = SW'(h_size_reg + x_size);
                        e_used  = 1'b0;
                    end
                end
                default:
                begin
                    e_used = x_used;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        op_next            = op_reg;
        k_next             = k_reg;
        count_next         = count_reg;
        frontier_next      = frontier_reg;
        done_next          = 1'b0;
        nfree_next         = nfree_reg;
        alloc_next         = alloc_reg;
        pct_next           = pct_reg;
        div_go_next        = 1'b0;
        cmd_next           = cmd_reg;
        req_next           = req_reg;
        where_next         = where_reg;
        found_next         = found_reg;
        pick_idx_next      = pick_idx_reg;
        pick_start_next    = pick_start_reg;
        pick_size_next     = pick_size_reg;
        prev_used_next     = prev_used_reg;
        prev_start_next    = prev_start_reg;
        prev_size_next     = prev_size_reg;
        left_free_next     = left_free_reg;
        left_start_next    = left_start_reg;
        left_size_next     = left_size_reg;
        right_free_next    = right_free_reg;
        right_size_next    = right_size_reg;
        upd_idx_next       = upd_idx_reg;
        new_start_next     = new_start_reg;
        new_size_next      = new_size_reg;
        new_used_next      = new_used_reg;
        pend_count_next    = pend_count_reg;
        pend_frontier_next = pend_frontier_reg;
        res_status_next    = res_status_reg;
        res_addr_next      = res_addr_reg;
        res_size_next      = res_size_reg;
        acc_nfree_next     = acc_nfree_reg;
        acc_alloc_next     = acc_alloc_reg;
        acc_free_next      = acc_free_reg;
        acc_big_next       = acc_big_reg;
        f_next             = f_reg;
        diff_next          = diff_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = command;
                    req_next   = request_size;
                    where_next = block_address;
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                k_next          = '0;
                found_next      = 1'b0;
                prev_used_next  = 1'b1;
                left_free_next  = 1'b0;
                right_free_next = 1'b0;
                res_status_next = blha_pkg::ST_OK;
                res_addr_next   = '0;
                res_size_next   = '0;
                if (cmd_reg > blha_pkg::CMD_FREE)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (cmd_reg == blha_pkg::CMD_FREE)
                begin
                    state_next = S_SCAN;
                end
                else if (req_reg == '0 || bump_end > (SW+1)'(HEAP_BYTES))
                begin
                    // capacity gate holds even if a free block would fit
                    res_status_next = blha_pkg::ST_NO_SPACE;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else if (cmd_reg == blha_pkg::CMD_BUMP)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                k_next = k_reg + 1'b1;
                if (x_valid)
                begin
                    case (cmd_reg)
                        blha_pkg::CMD_FIRST, blha_pkg::CMD_SPLIT:
                        begin
                            if (fit && !found_reg)
                            begin
                                found_next      = 1'b1;
                                pick_idx_next   = k_reg;
                                pick_start_next = x_start;
                                pick_size_next  = x_size;
                            end
                        end
                        blha_pkg::CMD_BEST:
                        begin
                            // strict compare keeps the lowest address on ties
                            if (fit && (!found_reg || x_size < pick_size_reg))
                            begin
                                found_next      = 1'b1;
                                pick_idx_next   = k_reg;
                                pick_start_next = x_start;
                                pick_size_next  = x_size;
                            end
                        end
                        blha_pkg::CMD_FREE:
                        begin
                            if (!found_reg && x_used && x_start == where_reg)
                            begin
                                found_next      = 1'b1;
                                pick_idx_next   = k_reg;
                                pick_start_next = x_start;
                                pick_size_next  = x_size;
                                left_free_next  = (k_reg != '0) && !prev_used_reg;
                                left_start_next = prev_start_reg;
                                left_size_next  = prev_size_reg;
                            end
                            if (found_reg && k_reg == pick_idx_reg + 1'b1)
                            begin
                                right_free_next = !x_used;
                                right_size_next = x_size;
                            end
                        end
                        default:
                        begin
                            found_next = found_reg;
                        end
                    endcase
                    prev_used_next  = x_used;
                    prev_start_next = x_start;
                    prev_size_next  = x_size;
                end
                if (last_n)
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                k_next             = '0;
                pend_count_next    = count_reg;
                pend_frontier_next = frontier_reg;
                res_status_next    = blha_pkg::ST_OK;
                state_next         = S_UPDATE;
                op_next            = OP_REPLACE;
                upd_idx_next       = pick_idx_reg;
                new_start_next     = pick_start_reg;
                new_size_next      = pick_size_reg;
                new_used_next      = 1'b1;
                res_addr_next      = pick_start_reg;
                res_size_next      = pick_size_reg;
                if (cmd_reg == blha_pkg::CMD_FREE)
                begin
                    if (!found_reg)
                    begin
                        res_status_next = blha_pkg::ST_NO_BLOCK;
                        res_addr_next   = '0;
                        res_size_next   = '0;
                        done_next       = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else if (left_free_reg)
                    begin
                        op_next         = OP_REMOVE;
                        pend_count_next = count_reg - 1'b1;
                        res_addr_next   = left_start_reg;
                        res_size_next   = SW'(left_size_reg + pick_size_reg);
                    end
                    else if (right_free_reg)
                    begin
                        op_next         = OP_REMOVE;
                        upd_idx_next    = pick_idx_reg + 1'b1;
                        pend_count_next = count_reg - 1'b1;
                        res_size_next   = SW'(pick_size_reg + right_size_reg);
                    end
                    else
                    begin
                        new_used_next = 1'b0;
                    end
                end
                else if (!found_reg)
                begin
                    // append at the frontier
                    if (count_reg >= CW'(MAX_ENTRIES))
                    begin
                        res_status_next = blha_pkg::ST_FULL;
                        res_addr_next   = '0;
                        res_size_next   = '0;
                        done_next       = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        upd_idx_next       = count_reg;
                        new_start_next     = frontier_reg[AW-1:0];
                        new_size_next      = req_reg;
                        pend_count_next    = count_reg + 1'b1;
                        pend_frontier_next = bump_end[SW-1:0];
                        res_addr_next      = frontier_reg[AW-1:0];
                        res_size_next      = req_reg;
                    end
                end
                else if (cmd_reg == blha_pkg::CMD_SPLIT && pick_size_reg > req_reg)
                begin
                    if (count_reg >= CW'(MAX_ENTRIES))
                    begin
                        res_status_next = blha_pkg::ST_FULL;
                        res_addr_next   = '0;
                        res_size_next   = '0;
                        done_next       = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        op_next         = OP_INSERT;
                        new_size_next   = req_reg;
                        pend_count_next = count_reg + 1'b1;
                        res_size_next   = req_reg;
                    end
                end
            end

            S_UPDATE:
            begin
                k_next = k_reg + 1'b1;
                if ((op_reg == OP_REMOVE) ? (k_reg == CW'(MAX_ENTRIES)) : last_n)
                begin
                    count_next     = pend_count_reg;
                    frontier_next  = pend_frontier_reg;
                    k_next         = '0;
                    acc_nfree_next = '0;
                    acc_alloc_next = '0;
                    acc_free_next  = '0;
                    acc_big_next   = '0;
                    state_next     = S_STATS;
                end
            end

            S_STATS:
            begin
                k_next = k_reg + 1'b1;
                if (x_valid)
                begin
                    if (x_used)
                    begin
                        acc_alloc_next = SW'(acc_alloc_reg + x_size);
                    end
                    else
                    begin
                        acc_nfree_next = acc_nfree_reg + 1'b1;
                        acc_free_next  = SW'(acc_free_reg + x_size);
                        if (x_size > acc_big_reg)
                        begin
                            acc_big_next = x_size;
                        end
                    end
                end
                if (last_n)
                begin
                    state_next = S_FINAL;
                end
            end

            S_FINAL:
            begin
                nfree_next = acc_nfree_reg;
                alloc_next = acc_alloc_reg;
                if (count_reg == '0 || f_sum == '0)
                begin
                    pct_next   = '0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    f_next      = f_sum;
                    diff_next   = f_sum - l_max;
                    div_go_next = 1'b1;
                    state_next  = S_DIVIDE;
                end
            end

            S_DIVIDE:
            begin
                if (div_res.done)
                begin
                    pct_next   = div_res.quotient;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            k_reg        <= '0;
            count_reg    <= '0;
            frontier_reg <= '0;
            done_reg     <= 1'b0;
            nfree_reg    <= '0;
            alloc_reg    <= '0;
            pct_reg      <= '0;
            div_go_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            count_reg    <= count_next;
            frontier_reg <= frontier_next;
            done_reg     <= done_next;
            nfree_reg    <= nfree_next;
            alloc_reg    <= alloc_next;
            pct_reg      <= pct_next;
            div_go_reg   <= div_go_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg            <= op_next;
        cmd_reg           <= cmd_next;
        req_reg           <= req_next;
        where_reg         <= where_next;
        found_reg         <= found_next;
        pick_idx_reg      <= pick_idx_next;
        pick_start_reg    <= pick_start_next;
        pick_size_reg     <= pick_size_next;
        prev_used_reg     <= prev_used_next;
        prev_start_reg    <= prev_start_next;
        prev_size_reg     <= prev_size_next;
        left_free_reg     <= left_free_next;
        left_start_reg    <= left_start_next;
        left_size_reg     <= left_size_next;
        right_free_reg    <= right_free_next;
        right_size_reg    <= right_size_next;
        upd_idx_reg       <= upd_idx_next;
        new_start_reg     <= new_start_next;
        new_size_reg      <= new_size_next;
        new_used_reg      <= new_used_next;
        h_start_reg       <= h_start_next;
        h_size_reg        <= h_size_next;
        h_used_reg        <= h_used_next;
        pend_count_reg    <= pend_count_next;
        pend_frontier_reg <= pend_frontier_next;
        res_status_reg    <= res_status_next;
        res_addr_reg      <= res_addr_next;
        res_size_reg      <= res_size_next;
        acc_nfree_reg     <= acc_nfree_next;
        acc_alloc_reg     <= acc_alloc_next;
        acc_free_reg      <= acc_free_next;
        acc_big_reg       <= acc_big_next;
        f_reg             <= f_next;
        diff_reg          <= diff_next;
    end

    assign busy              = state_reg != S_IDLE;
    assign done              = done_reg;
    assign status            = res_status_reg;
    assign result_address    = res_addr_reg;
    assign result_size       = res_size_reg;
    assign frontier          = frontier_reg;
    assign total_blocks      = count_reg;
    assign free_blocks       = nfree_reg;
    assign allocated_bytes   = alloc_reg;
    assign fragmentation_pct = pct_reg;

endmodule

FILE: design/blha_cell.sv
// ----------------------------------------------------------------------------
// blha_cell: one block-table entry in the rotating ring
// Loads its right neighbor's entry (the controller's, for the tail cell) whenever the ring shifts.
// ----------------------------------------------------------------------------
module blha_cell #(
    parameter int AW = 9,
    parameter int SW = 10
) (
    input  logic          clk,
    input  logic          en,
    input  logic [AW-1:0] start_in,
    input  logic [SW-1:0] size_in,
    input  logic          used_in,
    output logic [AW-1:0] start_out,
    output logic [SW-1:0] size_out,
    output logic          used_out
);

    logic [AW-1:0] start_reg;
    logic [SW-1:0] size_reg;
    logic          used_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            start_reg <= start_in;
            size_reg  <= size_in;
            used_reg  <= used_in;
        end
    end

    assign start_out = start_reg;
    assign size_out  = size_reg;
    assign used_out  = used_reg;

endmodule

FILE: design/blha_div.sv
// ----------------------------------------------------------------------------
// blha_div: fragmentation percentage divider
// floor(100 * diff / den), restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module blha_div #(
    parameter int SW = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic [SW-1:0]      diff,
    input  logic [SW-1:0]      den,
    output blha_pkg::div_res_t res
);

    localparam int NW = SW + blha_pkg::PCT_W;

    logic [NW-1:0]                  rem_reg, rem_next;
    logic [NW-1:0]                  dsh_reg, dsh_next;
    logic [blha_pkg::PCT_W-1:0]     q_reg, q_next;
    logic [blha_pkg::PCT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           run_reg, run_next;
    logic                           done_reg, done_next;
    logic                           fits;

    assign fits = rem_reg >= dsh_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (go)
        begin
            rem_next = NW'(diff) * NW'(blha_pkg::PCT_SCALE);
            dsh_next = NW'(den) << (blha_pkg::PCT_W - 1);
            q_next   = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            q_next   = {q_reg[blha_pkg::PCT_W-2:0], fits};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == blha_pkg::PCT_CNT_W'(blha_pkg::PCT_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign res.done     = done_reg;
    assign res.quotient = q_reg;

endmodule
